[hw/rtl/tsrg_pkg.sv]
// Shared types and constants for the timestamp replay guard.
`default_nettype none

package tsrg_pkg;

  localparam int unsigned Depth    = 32;
  localparam int unsigned SecW     = 32;
  localparam int unsigned UsecW    = 20;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_NEWER  = 3'd0,
    VERDICT_REPLAY = 3'd1,
    VERDICT_OLDER  = 3'd2,
    VERDICT_SKEW   = 3'd3,
    VERDICT_STORED = 3'd4
  } verdict_e;

  typedef enum logic {
    KIND_CHECK = 1'b0,
    KIND_ADD   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
  } stamp_t;

  typedef struct packed {
    logic newer;
    logic match;
    logic below_oldest;
  } cell_flags_t;

endpackage

`default_nettype wire

[hw/rtl/timestamp_replay_guard_core.sv]
// Top level of the timestamp replay guard: cell chain, sequencer and result register.
`default_nettype none

// The backlog is a chain of Depth cells, newest in cell 0; an add beat shifts
// every cell one place on, so the oldest entry drops off the end once full.
// An add answers "stored". A check registers the probe on accept; in ST_EVAL
// each cell compares it with its entry and registers its flags, and
// ST_RESOLVE combines the flags into the verdict, waiting for a free output.
// A new beat is taken once the previous result is taken or is being taken.
// No clearing pass is needed after reset.
module timestamp_replay_guard_core
  import tsrg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,   // stamp_sec[31:0], stamp_usec[51:32]
  input  wire logic                s_axis_tuser_i,   // kind
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o    // verdict[2:0]
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_EVAL    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_e;

  state_e      state_d, state_q;
  stamp_t      probe_d, probe_q;
  stamp_t      in_stamp;
  logic        in_fire;
  logic        out_free;
  logic        shift;
  logic        out_valid_d, out_valid_q;
  verdict_e    verdict_d, verdict_q;
  verdict_e    check_verdict;
  logic        any_match, any_below;

  stamp_t      chain_stamp [Depth];
  logic        chain_valid [Depth];
  cell_flags_t cell_flags  [Depth];

  assign in_stamp.sec  = s_axis_tdata_i[SecW-1:0];
  assign in_stamp.usec = s_axis_tdata_i[SecW+UsecW-1:SecW];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign shift           = in_fire && (s_axis_tuser_i == KIND_ADD);

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    stamp_t cell_stamp_in;
    logic   cell_valid_in;
    logic   cell_next_valid;

    if (i == 0) begin : g_head
      assign cell_stamp_in = in_stamp;
      assign cell_valid_in = 1'b1;
    end else begin : g_body
      assign cell_stamp_in = chain_stamp[i-1];
      assign cell_valid_in = chain_valid[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign cell_next_valid = 1'b0;
    end else begin : g_inner
      assign cell_next_valid = chain_valid[i+1];
    end

    tsrg_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .stamp_i      (cell_stamp_in),
      .valid_i      (cell_valid_in),
      .next_valid_i (cell_next_valid),
      .probe_i      (probe_q),
      .stamp_o      (chain_stamp[i]),
      .valid_o      (chain_valid[i]),
      .flags_o      (cell_flags[i])
    );
  end

  always_comb begin
    any_match = 1'b0;
    any_below = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      any_match = any_match | cell_flags[i].match;
      any_below = any_below | cell_flags[i].below_oldest;
    end
    if (cell_flags[0].newer) begin
      check_verdict = VERDICT_NEWER;
    end else if (any_match) begin
      check_verdict = VERDICT_REPLAY;
    end else if (any_below) begin
      check_verdict = VERDICT_OLDER;
    end else begin
      check_verdict = VERDICT_SKEW;
    end
  end

  always_comb begin
    state_d     = state_q;
    probe_d     = probe_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i == KIND_ADD) begin
            verdict_d   = VERDICT_STORED;
            out_valid_d = 1'b1;
          end else begin
            probe_d = in_stamp;
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (out_free) begin
          verdict_d   = check_verdict;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q   <= probe_d;
    verdict_q <= verdict_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-VerdictW){1'b0}}, verdict_q};

endmodule

`default_nettype wire

[hw/rtl/tsrg_cell.sv]
// One backlog cell: holds a timestamp, shifts it on, and compares it with the probe.
`default_nettype none

module tsrg_cell
  import tsrg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        shift_i,
  input  wire stamp_t      stamp_i,
  input  wire logic        valid_i,
  input  wire logic        next_valid_i,
  input  wire stamp_t      probe_i,
  output stamp_t           stamp_o,
  output logic             valid_o,
  output cell_flags_t      flags_o
);

  stamp_t      stamp_q;
  logic        valid_q;
  cell_flags_t flags_d, flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      stamp_q <= stamp_i;
    end
  end

  always_comb begin
    flags_d.newer = !valid_q || (probe_i.sec > stamp_q.sec) ||
                    ((probe_i.sec == stamp_q.sec) && (probe_i.usec > stamp_q.usec));
    flags_d.match = valid_q && (probe_i.sec == stamp_q.sec) &&
                    (probe_i.usec == stamp_q.usec);
    flags_d.below_oldest = valid_q && !next_valid_i && (probe_i.sec < stamp_q.sec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign stamp_o = stamp_q;
  assign valid_o = valid_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

[verif/tb_timestamp_replay_guard_core.sv]
// Self-checking testbench for timestamp_replay_guard_core with a built-in backlog predictor.
`timescale 1ns / 1ps

module tb_timestamp_replay_guard_core;
  import tsrg_pkg::*;

  typedef struct packed {
    kind_e  kind;
    stamp_t st;
  } beat_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  beat_t       pending_beats [$];
  verdict_e    verdicts_due [$];
  stamp_t      backlog [Depth];
  int unsigned backlog_fill = 0;
  int unsigned backlog_head = 0;

  int beats_planned = 0;
  int beats_taken   = 0;
  int fail_count    = 0;
  int verdict_hits [5];
  int send_gap      = 0;
  int send_quiet    = 0;
  int recv_hold     = 0;
  int recv_quiet    = 0;

  timestamp_replay_guard_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic verdict_e judge_stamp(beat_t b);
    int unsigned slot;
    int unsigned newest_slot;
    if (b.kind == KIND_ADD) begin
      if (backlog_fill >= Depth) begin
        slot = backlog_head;
        backlog_head = (backlog_head + 1) % Depth;
      end else begin
        slot = (backlog_head + backlog_fill) % Depth;
        backlog_fill++;
      end
      backlog[slot] = b.st;
      return VERDICT_STORED;
    end
    if (backlog_fill == 0) return VERDICT_NEWER;
    newest_slot = (backlog_head + backlog_fill - 1) % Depth;
    if (b.st.sec > backlog[newest_slot].sec) return VERDICT_NEWER;
    if (b.st.sec == backlog[newest_slot].sec && b.st.usec > backlog[newest_slot].usec)
      return VERDICT_NEWER;
    for (int unsigned i = 0; i < backlog_fill; i++) begin
      if (backlog[(backlog_head + i) % Depth] == b.st) return VERDICT_REPLAY;
    end
    if (b.st.sec < backlog[backlog_head].sec) return VERDICT_OLDER;
    return VERDICT_SKEW;
  endfunction

  function automatic void queue_beat(kind_e k, logic [SecW-1:0] sec, logic [UsecW-1:0] usec);
    beat_t b;
    b.kind    = k;
    b.st.sec  = sec;
    b.st.usec = usec;
    pending_beats.push_back(b);
  endfunction

  function automatic stamp_t next_stamp(stamp_t s);
    stamp_t n;
    n = s;
    if ($urandom_range(0, 3) == 0) begin
      n.sec  = s.sec + $urandom_range(1, 3);
      n.usec = UsecW'($urandom_range(0, 999999));
    end else if (s.usec < 999000) begin
      n.usec = UsecW'(s.usec + $urandom_range(1, 999));
    end else begin
      n.sec  = s.sec + 1;
      n.usec = UsecW'($urandom_range(0, 999));
    end
    return n;
  endfunction

  function automatic int draw_idle(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(8, 40);
    return $urandom_range(0, 15);
  endfunction

  // Sender: present one beat at a time, predict on acceptance.
  always @(posedge clk_i) begin
    beat_t b;
    beat_t nb;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        b.kind    = kind_e'(s_axis_tuser_i);
        b.st.sec  = s_axis_tdata_i[SecW-1:0];
        b.st.usec = s_axis_tdata_i[SecW+UsecW-1:SecW];
        verdicts_due.push_back(judge_stamp(b));
        beats_taken++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          s_axis_tvalid_i <= 1'b0;
          send_gap--;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= nb.kind;
          s_axis_tdata_i  <= {{(InDataW-SecW-UsecW){1'b0}}, nb.st.usec, nb.st.sec};
          send_gap = draw_idle(send_quiet);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest outstanding verdict.
  always @(posedge clk_i) begin
    logic [VerdictW-1:0] got;
    verdict_e            want;
    int                  hold;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_hold = 0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[VerdictW-1:0];
      if (verdicts_due.size() == 0) begin
        $error("verdict: expected nothing, got %0d", got);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        verdict_hits[int'(want)]++;
        if (got !== want) begin
          $error("verdict: expected %0d, got %0d", want, got);
          fail_count++;
        end
      end
      hold = draw_idle(recv_quiet);
      if (hold == 0) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        recv_hold = hold - 1;
      end
    end else if (!m_axis_tready_i) begin
      if (recv_hold == 0) m_axis_tready_i <= 1'b1;
      else recv_hold--;
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stamp_t clock_st;
    stamp_t probe;
    stamp_t recent [$];
    int     pick;
    int     idx;

    // Empty backlog, then replay, newer, older-than-oldest and skew cases.
    queue_beat(KIND_CHECK, 32'd0, 20'd0);
    queue_beat(KIND_CHECK, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_beat(KIND_ADD,   32'd1000, 20'd500);
    queue_beat(KIND_CHECK, 32'd1000, 20'd500);
    queue_beat(KIND_CHECK, 32'd1000, 20'd501);
    queue_beat(KIND_CHECK, 32'd1001, 20'd0);
    queue_beat(KIND_CHECK, 32'd999,  20'd999999);
    queue_beat(KIND_ADD,   32'd1000, 20'hFFFFF);
    queue_beat(KIND_CHECK, 32'd1000, 20'hFFFFE);
    queue_beat(KIND_CHECK, 32'd1000, 20'hFFFFF);
    queue_beat(KIND_ADD,   32'd2000, 20'd0);
    queue_beat(KIND_CHECK, 32'd1000, 20'd500);
    queue_beat(KIND_CHECK, 32'd1500, 20'd7);
    queue_beat(KIND_CHECK, 32'd0,    20'd0);
    queue_beat(KIND_ADD,   32'hFFFF_FFFF, 20'd999999);
    queue_beat(KIND_CHECK, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_beat(KIND_CHECK, 32'hFFFF_FFFF, 20'd999999);
    queue_beat(KIND_ADD,   32'd5, 20'd0);
    queue_beat(KIND_CHECK, 32'd6, 20'd0);
    queue_beat(KIND_CHECK, 32'd2000, 20'd0);

    clock_st.sec  = $urandom_range(0, 1000);
    clock_st.usec = '0;
    for (int i = 0; i < 1630; i++) begin
      if (i % 200 == 199) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) clock_st.sec = $urandom_range(0, 100);
        else if (pick == 1) clock_st.sec = $urandom;
        else clock_st.sec = 32'hFFFF_FFFF - $urandom_range(0, 400);
        clock_st.usec = UsecW'($urandom_range(0, 999999));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45 || recent.size() == 0) begin
        clock_st = next_stamp(clock_st);
        queue_beat(KIND_ADD, clock_st.sec, clock_st.usec);
        recent.push_back(clock_st);
        if (recent.size() > 40) void'(recent.pop_front());
      end else if (pick < 60) begin
        probe = next_stamp(clock_st);
        queue_beat(KIND_CHECK, probe.sec, probe.usec);
      end else if (pick < 75) begin
        probe = recent[$urandom_range(0, recent.size() - 1)];
        queue_beat(KIND_CHECK, probe.sec, probe.usec);
      end else if (pick < 83) begin
        idx   = (recent.size() > Depth) ? recent.size() - Depth : 0;
        probe.sec  = recent[idx].sec - $urandom_range(1, 100);
        probe.usec = UsecW'($urandom_range(0, 999999));
        queue_beat(KIND_CHECK, probe.sec, probe.usec);
      end else if (pick < 93) begin
        probe = recent[recent.size() - 1];
        if (probe.usec > 0) begin
          probe.usec = probe.usec - 1;
        end else begin
          probe.sec  = probe.sec - 1;
          probe.usec = 20'd999999;
        end
        queue_beat(KIND_CHECK, probe.sec, probe.usec);
      end else begin
        queue_beat(kind_e'($urandom_range(0, 1)), $urandom,
                   UsecW'($urandom_range(0, 20'hFFFFF)));
      end
    end
    beats_planned = pending_beats.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken < beats_planned) @(posedge clk_i);
    while (verdicts_due.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d beats through a %0d-entry backlog with random gaps and stalls.",
             beats_taken, Depth);
    $display("Verdicts: newer %0d, replay %0d, older %0d, skew %0d, stored %0d.",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
             verdict_hits[4]);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tsrg_pkg.sv
hw/rtl/tsrg_cell.sv
hw/rtl/timestamp_replay_guard_core.sv
verif/tb_timestamp_replay_guard_core.sv
